FILE: rtl/core/vfc_pkg.sv
// shared types and constants for the voxel face culling core
package vfc_pkg;

  // default chunk edge length
  localparam int unsigned CHUNK_SIZE_DEF = 16;

  // field widths
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned FACE_CW  = 4;
  localparam int unsigned SIDE_W   = 3;
  localparam int unsigned INDEX_W  = 17;
  localparam int unsigned NUM_SIDES = 6;

  // vertex index step per emitted quad
  localparam logic [INDEX_W-1:0] QUAD_VERTS = INDEX_W'(4);

  // command codes on the input port
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // operation carried by one queued item
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_BEGIN,
    OP_EVAL
  } op_e;

  // queued item: padded coordinates run 0 .. CHUNK_SIZE+1
  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] ux;
    logic [COORD_W-1:0] uy;
    logic [COORD_W-1:0] uz;
    logic               solid;
  } queue_entry_t;

  // front to queue
  typedef struct packed {
    logic         push;
    queue_entry_t entry;
  } push_req_t;

  // back part sequencer
  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_EXEC,
    BS_READ,
    BS_EMIT
  } back_state_e;

endpackage

FILE: rtl/core/vfc_front.sv
// front part: accepts commands, range checks them, queues the useful ones
module vfc_front #(
  parameter int unsigned CHUNK_SIZE = vfc_pkg::CHUNK_SIZE_DEF
) (
  input  logic                                 start_i,
  input  logic                                 busy_i,
  input  logic [1:0]                           cmd_i,
  input  logic signed [vfc_pkg::COORD_W-1:0]   pos_x_i,
  input  logic signed [vfc_pkg::COORD_W-1:0]   pos_y_i,
  input  logic signed [vfc_pkg::COORD_W-1:0]   pos_z_i,
  input  logic                                 solid_i,
  output vfc_pkg::push_req_t                   push_o
);
  import vfc_pkg::*;

  logic accept;
  int   xs, ys, zs;
  logic in_pad, in_chunk;

  // sign extend and check ranges
  always_comb begin
    xs       = int'(pos_x_i);
    ys       = int'(pos_y_i);
    zs       = int'(pos_z_i);
    in_pad   = (xs >= -1) && (xs <= int'(CHUNK_SIZE)) &&
               (ys >= -1) && (ys <= int'(CHUNK_SIZE)) &&
               (zs >= -1) && (zs <= int'(CHUNK_SIZE));
    in_chunk = (xs >= 0) && (xs < int'(CHUNK_SIZE)) &&
               (ys >= 0) && (ys < int'(CHUNK_SIZE)) &&
               (zs >= 0) && (zs < int'(CHUNK_SIZE));
  end

  assign accept = start_i && !busy_i;

  // classify the item and build the queue entry
  always_comb begin
    push_o.push        = 1'b0;
    push_o.entry.op    = OP_WRITE;
    push_o.entry.ux    = COORD_W'(xs + 1);
    push_o.entry.uy    = COORD_W'(ys + 1);
    push_o.entry.uz    = COORD_W'(zs + 1);
    push_o.entry.solid = solid_i;
    unique case (cmd_i)
      CMD_WRITE: begin
        push_o.push     = accept && in_pad;
        push_o.entry.op = OP_WRITE;
      end
      CMD_BEGIN: begin
        push_o.push     = accept;
        push_o.entry.op = OP_BEGIN;
      end
      CMD_EVAL: begin
        push_o.push     = accept && in_chunk;
        push_o.entry.op = OP_EVAL;
      end
      default: begin
        push_o.push = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/vfc_queue.sv
// short item queue between the front and back parts
module vfc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vfc_pkg::push_req_t    push_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output logic                  full_o,
  output vfc_pkg::queue_entry_t entry_o
);
  import vfc_pkg::*;

  queue_entry_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, wptr_d;
  logic [QPTR_W-1:0]   rptr_q, rptr_d;
  logic [QPTR_W:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign entry_o = slot_q[rptr_q];
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_i.entry;
    end
  end

  // a push never arrives while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i.push && full_o))
    else $error("queue overflow");

endmodule

FILE: rtl/core/vfc_back.sv
// back part: occupancy store, neighbour reads and face emission
module vfc_back #(
  parameter int unsigned CHUNK_SIZE = vfc_pkg::CHUNK_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  vfc_pkg::queue_entry_t          q_entry_i,
  output logic                           q_pop_o,
  output logic                           clearing_o,
  output logic                           face_valid_o,
  output logic [vfc_pkg::SIDE_W-1:0]     face_side_o,
  output logic [vfc_pkg::FACE_CW-1:0]    face_x_o,
  output logic [vfc_pkg::FACE_CW-1:0]    face_y_o,
  output logic [vfc_pkg::FACE_CW-1:0]    face_z_o,
  output logic [vfc_pkg::INDEX_W-1:0]    base_index_o,
  output logic                           last_o
);
  import vfc_pkg::*;

  localparam int unsigned PAD   = CHUNK_SIZE + 2;
  localparam int unsigned PAD2  = PAD * PAD;
  localparam int unsigned CELLS = PAD2 * PAD;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] STRIDE_Y = AW'(PAD);
  localparam logic [AW-1:0] STRIDE_Z = AW'(PAD2);
  localparam logic [2:0]    STEP_CTR = 3'd1;
  localparam logic [2:0]    STEP_END = 3'd7;

  back_state_e          state_q, state_d;
  logic                 occ_q [CELLS];
  logic [AW-1:0]        clr_addr_q, clr_addr_d;
  logic [2:0]           step_q, step_d;
  logic [NUM_SIDES-1:0] mask_q, mask_d;
  logic [INDEX_W-1:0]   idx_q, idx_d;

  // current item
  op_e                  cur_op_q;
  logic [COORD_W-1:0]   cur_ux_q, cur_uy_q, cur_uz_q;
  logic                 cur_solid_q;
  logic [AW-1:0]        addr_q;
  logic [AW-1:0]        pop_addr;

  // memory ports
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic                 mem_wd;
  logic [AW-1:0]        rd_addr;
  logic                 rd_data_q;

  // face selection
  logic [SIDE_W-1:0]    sel_side;
  logic [NUM_SIDES-1:0] rest_mask;
  logic                 emit;

  // face output registers
  logic                 face_valid_q;
  logic [SIDE_W-1:0]    face_side_q;
  logic [INDEX_W-1:0]   base_q;
  logic                 last_q;

  // linear address of the popped item
  assign pop_addr = AW'((AW'(q_entry_i.uz) * STRIDE_Y + AW'(q_entry_i.uy)) * STRIDE_Y
                        + AW'(q_entry_i.ux));

  // lowest exposed side first
  always_comb begin
    sel_side = '0;
    for (int i = NUM_SIDES - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel_side = SIDE_W'(i);
      end
    end
    rest_mask = mask_q & ~(NUM_SIDES'(1) << sel_side);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_CLEAR: begin
        if (clr_addr_q == CLR_LAST) state_d = BS_IDLE;
      end
      BS_IDLE: begin
        if (q_valid_i) state_d = BS_EXEC;
      end
      BS_EXEC: begin
        state_d = (cur_op_q == OP_EVAL) ? BS_READ : BS_IDLE;
      end
      BS_READ: begin
        if (step_q == STEP_CTR && !rd_data_q) begin
          state_d = BS_IDLE;
        end else if (step_q == STEP_END) begin
          state_d = (mask_d != '0) ? BS_EMIT : BS_IDLE;
        end
      end
      BS_EMIT: begin
        if (rest_mask == '0) state_d = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // state outputs and datapath controls
  always_comb begin
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = addr_q;
    mem_wd     = cur_solid_q;
    clr_addr_d = clr_addr_q;
    step_d     = step_q;
    mask_d     = mask_q;
    idx_d      = idx_q;
    emit       = 1'b0;
    unique case (state_q)
      BS_CLEAR: begin
        mem_we     = 1'b1;
        mem_wa     = clr_addr_q;
        mem_wd     = 1'b0;
        clr_addr_d = clr_addr_q + 1'b1;
      end
      BS_IDLE: begin
        q_pop_o = q_valid_i;
      end
      BS_EXEC: begin
        step_d = '0;
        mask_d = '0;
        if (cur_op_q == OP_WRITE) mem_we = 1'b1;
        if (cur_op_q == OP_BEGIN) idx_d = '0;
      end
      BS_READ: begin
        step_d = step_q + 1'b1;
        if (step_q > STEP_CTR) begin
          mask_d = mask_q | (NUM_SIDES'(!rd_data_q) << (step_q - 3'd2));
        end
      end
      BS_EMIT: begin
        emit   = 1'b1;
        mask_d = rest_mask;
        idx_d  = idx_q + QUAD_VERTS;
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  // read address: center, then down, up, left, right, back, front
  always_comb begin
    case (step_q)
      3'd1:    rd_addr = addr_q - STRIDE_Y;
      3'd2:    rd_addr = addr_q + STRIDE_Y;
      3'd3:    rd_addr = addr_q - 1'b1;
      3'd4:    rd_addr = addr_q + 1'b1;
      3'd5:    rd_addr = addr_q - STRIDE_Z;
      3'd6:    rd_addr = addr_q + STRIDE_Z;
      default: rd_addr = addr_q;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BS_CLEAR;
      clr_addr_q   <= '0;
      step_q       <= '0;
      mask_q       <= '0;
      idx_q        <= '0;
      face_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      step_q       <= step_d;
      mask_q       <= mask_d;
      idx_q        <= idx_d;
      face_valid_q <= emit;
    end
  end

  // item and face payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_op_q    <= q_entry_i.op;
      cur_ux_q    <= q_entry_i.ux;
      cur_uy_q    <= q_entry_i.uy;
      cur_uz_q    <= q_entry_i.uz;
      cur_solid_q <= q_entry_i.solid;
      addr_q      <= pop_addr;
    end
    if (emit) begin
      face_side_q <= sel_side;
      base_q      <= idx_q;
      last_q      <= (rest_mask == '0);
    end
  end

  // occupancy store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      occ_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= occ_q[rd_addr];
  end

  assign clearing_o   = (state_q == BS_CLEAR);
  assign face_valid_o = face_valid_q;
  assign face_side_o  = face_side_q;
  assign face_x_o     = FACE_CW'(cur_ux_q - 1'b1);
  assign face_y_o     = FACE_CW'(cur_uy_q - 1'b1);
  assign face_z_o     = FACE_CW'(cur_uz_q - 1'b1);
  assign base_index_o = base_q;
  assign last_o       = last_q;

  // a face strobe only follows an emit cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    face_valid_q |-> $past(state_q == BS_EMIT))
    else $error("face strobe without emit cycle");

  // emission never runs with nothing left to emit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_EMIT) |-> (mask_q != '0))
    else $error("emit with empty side mask");

  // faces of one voxel come back to back with the index stepping by four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (face_valid_q && !last_q) |=>
      (face_valid_q && base_q == INDEX_W'($past(base_q) + QUAD_VERTS)))
    else $error("face run broken or index step wrong");

  // the store is not written while a voxel is being evaluated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_READ || state_q == BS_EMIT) |-> !mem_we)
    else $error("store write during evaluation");

endmodule

FILE: rtl/core/voxel_face_culling_core.sv
// top level of the voxel face culling core
//
//  channel   direction  handshake                     fields
//  command   in         start && !busy                cmd, pos_x, pos_y, pos_z, solid
//  face      out        face_valid_o, one cycle each  face_side, face_x/y/z, base_index, last
//
// after reset the occupancy store is cleared one cell a cycle, all (CHUNK_SIZE+2)^3
// cells (5832 at the default size), with busy held high throughout.
// a write or begin item passes the idle and execute states of the back part; an
// evaluate then reads the store in the read state (one read port, center then six
// neighbours) and emits one face a cycle per exposed side; an empty voxel ends after the center read.
// a 4-deep queue lets the front take items while the back part works; busy is
// high while the queue is full. faces cannot be stalled by the receiver.
module voxel_face_culling_core #(
  parameter int unsigned CHUNK_SIZE = vfc_pkg::CHUNK_SIZE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           cmd_i,
  input  logic signed [vfc_pkg::COORD_W-1:0]   pos_x_i,
  input  logic signed [vfc_pkg::COORD_W-1:0]   pos_y_i,
  input  logic signed [vfc_pkg::COORD_W-1:0]   pos_z_i,
  input  logic                                 solid_i,
  output logic                                 face_valid_o,
  output logic [vfc_pkg::SIDE_W-1:0]           face_side_o,
  output logic [vfc_pkg::FACE_CW-1:0]          face_x_o,
  output logic [vfc_pkg::FACE_CW-1:0]          face_y_o,
  output logic [vfc_pkg::FACE_CW-1:0]          face_z_o,
  output logic [vfc_pkg::INDEX_W-1:0]          base_index_o,
  output logic                                 last_o
);
  import vfc_pkg::*;

  push_req_t    push_req;
  queue_entry_t q_entry;
  logic         q_valid;
  logic         q_full;
  logic         q_pop;
  logic         clearing;

  // hold off items during the clearing pass or when the queue is full
  assign busy = clearing || q_full;

  vfc_front #(
    .CHUNK_SIZE (CHUNK_SIZE)
  ) u_front (
    .start_i (start),
    .busy_i  (busy),
    .cmd_i   (cmd_i),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .pos_z_i (pos_z_i),
    .solid_i (solid_i),
    .push_o  (push_req)
  );

  vfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_req),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .entry_o (q_entry)
  );

  vfc_back #(
    .CHUNK_SIZE (CHUNK_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .clearing_o   (clearing),
    .face_valid_o (face_valid_o),
    .face_side_o  (face_side_o),
    .face_x_o     (face_x_o),
    .face_y_o     (face_y_o),
    .face_z_o     (face_z_o),
    .base_index_o (base_index_o),
    .last_o       (last_o)
  );

endmodule
